// ----- hw/rtl/pcrc_pkg.sv -----
`timescale 1ns / 1ps

package pcrc_pkg;

   // Reflected CRC-32, zlib flavor
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [31:0] TYPE_BYTES = 32'd4;

   localparam int QUEUE_DEPTH_DEF = 4;

   // Output sequencer phases for one request
   typedef enum logic [3:0] {
      PH_LEN0 = 4'd0,
      PH_LEN1 = 4'd1,
      PH_LEN2 = 4'd2,
      PH_LEN3 = 4'd3,
      PH_DATA = 4'd4,
      PH_CRC0 = 4'd5,
      PH_CRC1 = 4'd6,
      PH_CRC2 = 4'd7,
      PH_CRC3 = 4'd8
   } phase_type;

   // rsp_tuser bit positions
   localparam int USER_DONE_BIT = 0;
   localparam int USER_ERR_BIT  = 1;

   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [30:0] length;
      logic [31:0] crc;     // already complemented, valid when last
      logic        err;     // length check, valid when last
   } pcrc_entry_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/pcrc_front.sv -----
`timescale 1ns / 1ps

module pcrc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              data_byte,
   input  logic                    first_byte,
   input  logic                    last_byte,
   input  logic [30:0]             body_length,
   output logic                    push_valid,
   input  logic                    push_ready,
   output pcrc_pkg::pcrc_entry_type push_entry
);
   import pcrc_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic [31:0] count_ff, count_in;
   logic [30:0] decl_ff, decl_in;

   logic [31:0] crc_base, crc_next;
   logic [31:0] count_base, count_next;
   logic        accept;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;

   always_comb begin
      crc_base   = first_byte ? CRC_PRESET : crc_ff;
      count_base = first_byte ? 32'd0 : count_ff;
      decl_in    = first_byte ? body_length : decl_ff;
      crc_next   = crc_byte(crc_base, data_byte);
      count_next = (count_base == 32'hFFFF_FFFF) ? count_base : count_base + 32'd1;

      push_entry.data   = data_byte;
      push_entry.first  = first_byte;
      push_entry.last   = last_byte;
      push_entry.length = decl_in;
      push_entry.crc    = ~crc_next;
      push_entry.err    = (count_next < TYPE_BYTES) ||
                          ((count_next - TYPE_BYTES) != {1'b0, decl_in});

      crc_in   = last_byte ? CRC_PRESET : crc_next;
      count_in = last_byte ? 32'd0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_PRESET;
         count_ff <= 32'd0;
         decl_ff  <= 31'd0;
      end else if (accept) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         decl_ff  <= decl_in;
      end
   end

endmodule

// ----- hw/rtl/pcrc_queue.sv -----
`timescale 1ns / 1ps

module pcrc_queue #(
   parameter int DEPTH = pcrc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  pcrc_pkg::pcrc_entry_type push_entry,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output pcrc_pkg::pcrc_entry_type pop_entry
);
   import pcrc_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

   pcrc_entry_type entries [DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/pcrc_back.sv -----
`timescale 1ns / 1ps

module pcrc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  pcrc_pkg::pcrc_entry_type pop_entry,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [7:0]              out_byte,
   output logic                    out_last,
   output logic                    out_done,
   output logic                    out_err
);
   import pcrc_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       started_ff, started_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       err_ff, err_in;

   phase_type  cur_phase, end_phase;
   logic       load_en, emit, at_end;

   assign load_en   = !valid_ff || out_ready;
   assign emit      = load_en && pop_valid;
   assign cur_phase = started_ff ? phase_ff : (pop_entry.first ? PH_LEN0 : PH_DATA);
   assign end_phase = pop_entry.last ? PH_CRC3 : PH_DATA;
   assign at_end    = (cur_phase == end_phase);
   assign pop_ready = load_en && at_end;

   // byte for the current phase
   always_comb begin
      unique case (cur_phase)
         PH_LEN0: byte_in = {1'b0, pop_entry.length[30:24]};
         PH_LEN1: byte_in = pop_entry.length[23:16];
         PH_LEN2: byte_in = pop_entry.length[15:8];
         PH_LEN3: byte_in = pop_entry.length[7:0];
         PH_DATA: byte_in = pop_entry.data;
         PH_CRC0: byte_in = pop_entry.crc[31:24];
         PH_CRC1: byte_in = pop_entry.crc[23:16];
         PH_CRC2: byte_in = pop_entry.crc[15:8];
         PH_CRC3: byte_in = pop_entry.crc[7:0];
         default: byte_in = 8'd0;
      endcase
      last_in = at_end;
      done_in = (cur_phase == PH_CRC3);
      err_in  = (cur_phase == PH_CRC3) && pop_entry.err;
   end

   always_comb begin
      valid_in   = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      phase_in   = phase_ff;
      started_in = started_ff;
      if (emit) begin
         started_in = !at_end;
         phase_in   = phase_type'(cur_phase + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         phase_ff   <= PH_LEN0;
      end else begin
         valid_ff   <= valid_in;
         started_ff <= started_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         done_ff <= done_in;
         err_ff  <= err_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;
   assign out_err   = err_ff;

endmodule

// ----- hw/rtl/png_chunk_crc32_framer_top.sv -----
`timescale 1ns / 1ps

// PNG chunk framer with CRC-32. Each request on req_ carries one chunk byte
// (type or data); the block passes it through on rsp_, preceded by the
// four big-endian length bytes when the request is marked first, and
// followed by the four CRC bytes (reflected CRC-32, zlib style, over type
// and data) when it is marked last (req_tlast). The final CRC byte carries
// chunk_done and the length check flag. Rate: a request is taken whenever
// the queue between front and back has room; the back sequencer puts out
// one response per cycle unless rsp_tready stalls it, so a request yields
// one byte for a plain request, 5 with a header or a trailer, 9 with both.
// The queue of QUEUE_DEPTH entries absorbs that difference across a chunk.
module png_chunk_crc32_framer_top #(
   parameter int QUEUE_DEPTH = pcrc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [38:8] body_length, [39] zero
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] chunk_done, [1] length_error
   output logic        rsp_tlast    // run_last
);
   import pcrc_pkg::*;

   logic           push_valid, push_ready;
   pcrc_entry_type push_entry;
   logic           pop_valid, pop_ready;
   pcrc_entry_type pop_entry;
   logic           done_bit, err_bit;

   // front: CRC update, byte count, length check
   pcrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata[7:0]),
      .first_byte  (req_tuser),
      .last_byte   (req_tlast),
      .body_length (req_tdata[38:8]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // decouples the one-per-cycle front (stalled only by a full queue) from the multi-byte back
   pcrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // back: serializes header, byte and trailer into registered output
   pcrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_done  (done_bit),
      .out_err   (err_bit)
   );

   assign rsp_tuser[USER_DONE_BIT] = done_bit;
   assign rsp_tuser[USER_ERR_BIT]  = err_bit;

`ifndef NO_ASSERTIONS
   // chunk end always closes the run of its request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && done_bit) |-> rsp_tlast)
      else $error("chunk_done without tlast");

   // length flag only on the final CRC byte
   a_err_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && err_bit) |-> done_bit)
      else $error("length_error outside chunk end");

   // a request is only dropped into the queue when the front takes it
   a_push_matches_accept: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) |-> (req_tvalid && req_tready))
      else $error("queue push without request accept");
`endif

endmodule
